[rtl/core/fsba_pkg.sv]
// Types and constants shared by the fit-strategy block allocator.
`default_nettype none
package fsba_pkg;

   localparam int INDEX_W    = 5;
   localparam int FIELD_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam int STRAT_W    = 2;
   localparam int ACTIVE_W   = 6;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
   localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
   localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_STRATEGY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE   = 1'd1;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 6'd32;

   typedef struct packed {
      logic               op;
      logic [INDEX_W-1:0] block_index;
      logic [FIELD_W-1:0] size_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] granted_block;
      logic [FIELD_W-1:0] fragment;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic start;
      logic scan_en;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } ctrl_sts_type;

endpackage
`default_nettype wire

[rtl/core/fit_strategy_block_allocator_unit.sv]
// Top level of the fit-strategy block allocator: controller plus datapath.
//
//   channel | ports                                  | payload
//   --------+----------------------------------------+--------------------------------
//   request | req_valid, req_ready, req_data         | op, block_index, size_value
//   result  | rsp_valid, rsp_ready, rsp_data         | found, granted_block, fragment
//   config  | csr_we, csr_index, csr_wdata           | strategy, active_blocks
//
// A load gives no result.
// An allocate scans min(active_blocks, NUM_BLOCKS) blocks before its result (none when
// no block is active): the scan reads one block per cycle.
// One request is worked on at a time; loads are taken while a result waits.
// A result still waiting at the end of a scan holds the commit and the request side.
// Reset clears the used flags and sets strategy to first fit and active_blocks to 32;
// block sizes hold no value until loaded.
`default_nettype none
module fit_strategy_block_allocator_unit #(
   parameter int NUM_BLOCKS = 32,
   parameter int SIZE_BITS  = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire fsba_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output fsba_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [fsba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fsba_pkg::CSR_DATA_W-1:0] csr_wdata
);

   fsba_pkg::ctrl_cmd_type cmd;
   fsba_pkg::ctrl_sts_type sts;

   fsba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.op),
      .sts       (sts),
      .cmd       (cmd)
   );

   fsba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[rtl/core/fsba_ctrl.sv]
// Controller state machine: takes requests and sequences load, scan and commit.
`default_nettype none
module fsba_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   input  wire fsba_pkg::ctrl_sts_type sts,
   output fsba_pkg::ctrl_cmd_type     cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.load    = accept && (req_op == fsba_pkg::OP_LOAD);
      cmd.start   = accept && (req_op == fsba_pkg::OP_ALLOC);
      cmd.scan_en = (state_ff == ST_SCAN);
      cmd.commit  = (state_ff == ST_SCAN) && sts.scan_done && sts.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/fsba_datapath.sv]
// Datapath: size memory, used flags, scan pointer, fit selection and result register.
`default_nettype none
module fsba_datapath #(
   parameter int NUM_BLOCKS = 32,
   parameter int SIZE_BITS  = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fsba_pkg::req_type                   req_data,
   input  wire fsba_pkg::ctrl_cmd_type              cmd,
   output fsba_pkg::ctrl_sts_type                   sts,
   input  wire logic                                csr_we,
   input  wire logic [fsba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fsba_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output fsba_pkg::rsp_type                        rsp_data
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   logic [SIZE_BITS-1:0]         size_mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0]        used_ff;

   logic [fsba_pkg::STRAT_W-1:0] strategy_ff;
   logic [fsba_pkg::ACTIVE_W-1:0] active_ff;

   logic [CNT_W-1:0]             ptr_ff;
   logic [CNT_W-1:0]             limit_ff;
   logic [CNT_W-1:0]             limit_in;
   logic [SIZE_BITS-1:0]         req_size_ff;

   logic                         rd_valid_ff;
   logic                         rd_valid_in;
   logic [IDX_W-1:0]             rd_idx_ff;
   logic [SIZE_BITS-1:0]         rd_size_ff;
   logic                         rd_used_ff;

   logic                         have_ff;
   logic [IDX_W-1:0]             pick_idx_ff;
   logic [SIZE_BITS-1:0]         pick_size_ff;
   logic                         cand;
   logic                         take;

   logic                         rsp_valid_ff;
   fsba_pkg::rsp_type            rsp_data_ff;

   logic [IDX_W-1:0]             ld_addr;
   logic                         ld_in_range;

   assign ld_addr     = IDX_W'(req_data.block_index);
   assign ld_in_range = (32'(req_data.block_index) < NUM_BLOCKS);

   always_comb begin
      if (32'(active_ff) > NUM_BLOCKS) begin
         limit_in = CNT_W'(NUM_BLOCKS);
      end else begin
         limit_in = CNT_W'(active_ff);
      end
   end

   assign rd_valid_in = cmd.scan_en && (ptr_ff < limit_ff);

   assign cand = rd_valid_ff && !rd_used_ff && (rd_size_ff >= req_size_ff);

   always_comb begin
      take = 1'b0;
      if (cand) begin
         if (!have_ff) begin
            take = 1'b1;
         end else begin
            case (strategy_ff)
               fsba_pkg::STRAT_BEST:  take = (rd_size_ff < pick_size_ff);
               fsba_pkg::STRAT_WORST: take = (rd_size_ff > pick_size_ff);
               default:               take = 1'b0;
            endcase
         end
      end
   end

   assign sts.scan_done = (ptr_ff == limit_ff) && !rd_valid_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= fsba_pkg::STRAT_FIRST;
         active_ff   <= fsba_pkg::ACTIVE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fsba_pkg::CSR_STRATEGY: strategy_ff <= csr_wdata[fsba_pkg::STRAT_W-1:0];
            fsba_pkg::CSR_ACTIVE:   active_ff   <= csr_wdata[fsba_pkg::ACTIVE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // size memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && ld_in_range) begin
         size_mem[ld_addr] <= SIZE_BITS'(req_data.size_value);
      end
      rd_size_ff <= size_mem[ptr_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.load && ld_in_range) begin
         used_ff[ld_addr] <= 1'b0;
      end else if (cmd.commit && have_ff) begin
         used_ff[pick_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         limit_ff    <= '0;
         rd_valid_ff <= 1'b0;
         have_ff     <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         if (cmd.start) begin
            ptr_ff   <= '0;
            limit_ff <= limit_in;
            have_ff  <= 1'b0;
         end else begin
            if (rd_valid_in) begin
               ptr_ff <= ptr_ff + CNT_W'(1);
            end
            if (take) begin
               have_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_size_ff <= SIZE_BITS'(req_data.size_value);
      end
      rd_idx_ff  <= ptr_ff[IDX_W-1:0];
      rd_used_ff <= used_ff[ptr_ff[IDX_W-1:0]];
      if (take) begin
         pick_idx_ff  <= rd_idx_ff;
         pick_size_ff <= rd_size_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (have_ff) begin
            rsp_data_ff.found         <= 1'b1;
            rsp_data_ff.granted_block <= fsba_pkg::INDEX_W'(pick_idx_ff);
            rsp_data_ff.fragment      <= fsba_pkg::FIELD_W'(pick_size_ff - req_size_ff);
         end else begin
            rsp_data_ff.found         <= 1'b0;
            rsp_data_ff.granted_block <= '0;
            rsp_data_ff.fragment      <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && have_ff) |-> !used_ff[pick_idx_ff])
      else $error("granted block already in use");

   a_grant_marks_used: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && have_ff) |=> used_ff[$past(pick_idx_ff)])
      else $error("granted block not marked used");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= limit_ff)
      else $error("scan pointer past limit");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_valid_ff && (rsp_data_ff.found == $past(have_ff))))
      else $error("committed result not presented");

endmodule
`default_nettype wire
